// ----- hw/rtl/kgoc_pkg.sv -----
package kgoc_pkg;

   // field widths
   localparam int KEY_W    = 10;
   localparam int SAMPLE_W = 10;
   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 18;
   localparam int GAIN_W   = 14;
   localparam int OFFSET_W = 9;
   localparam int STEP_W   = 9;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int QUAD_W   = 6;

   typedef logic [KEY_W-1:0]           key_level_type;
   typedef logic [SAMPLE_W-1:0]        sample_type;
   typedef logic [MODE_W-1:0]          mode_type;
   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic [GAIN_W-1:0]          gain_type;
   typedef logic signed [OFFSET_W-1:0] offset_type;
   typedef logic [STEP_W-1:0]          step_type;
   typedef logic [CSR_W-1:0]           csr_data_type;
   typedef logic [CSR_IDX_W-1:0]       csr_idx_type;
   typedef logic [QUAD_W-1:0]          quad_type;

   // decoded keypad
   typedef struct packed {
      logic right;
      logic up;
      logic down;
      logic left;
      logic sel;
   } key_flags_type;

   // mode codes
   localparam mode_type MODE_OFF    = 3'd0;
   localparam mode_type MODE_RUN    = 3'd1;
   localparam mode_type MODE_GAIN   = 3'd2;
   localparam mode_type MODE_OFFSET = 3'd3;
   localparam mode_type MODE_CLEAR  = 3'd4;

   // register indexes
   localparam csr_idx_type CSR_REPEAT_TICKS     = 1'b0;
   localparam csr_idx_type CSR_CLEAR_HOLD_TICKS = 1'b1;

   localparam csr_data_type REPEAT_TICKS_RESET     = 16'd300;
   localparam csr_data_type CLEAR_HOLD_TICKS_RESET = 16'd2000;

   // keypad ladder thresholds
   localparam key_level_type KEY_RIGHT_LT = 10'd50;
   localparam key_level_type KEY_UP_GT    = 10'd100;
   localparam key_level_type KEY_UP_LT    = 10'd200;
   localparam key_level_type KEY_DOWN_GT  = 10'd260;
   localparam key_level_type KEY_DOWN_LT  = 10'd350;
   localparam key_level_type KEY_LEFT_GT  = 10'd400;
   localparam key_level_type KEY_LEFT_LT  = 10'd650;
   localparam key_level_type KEY_SEL_GT   = 10'd700;
   localparam key_level_type KEY_SEL_LT   = 10'd990;

   // quadrature history patterns
   localparam quad_type QUAD_RESET = 6'b000011;
   localparam quad_type QUAD_UP_A  = 6'b001011;
   localparam quad_type QUAD_UP_B  = 6'b110100;
   localparam quad_type QUAD_DN_A  = 6'b000111;
   localparam quad_type QUAD_DN_B  = 6'b111000;

   // tuning limits, hundredths
   localparam gain_type   GAIN_RESET   = 14'd100;
   localparam offset_type OFFSET_RESET = 9'sd0;
   localparam step_type   STEP_RESET   = 9'd50;
   localparam int GAIN_MAX        = 9990;
   localparam int GAIN_MIN        = 1;
   localparam int OFFSET_LIMIT    = 250;
   localparam int GAIN_STEP_INC   = 10;
   localparam int GAIN_STEP_MAX   = 300;
   localparam int OFFSET_STEP_INC = 5;
   localparam int OFFSET_STEP_MAX = 200;
   localparam int MINMAX_ARM      = 10000;

   // sample scaling: value = trunc(gain*(125*sample + 256*offset) / 25600)
   localparam int SAMPLE_MULT = 125;
   // floor(q/100) = (q*DIV100_RECIP) >> 30, exact for q < 2^23
   localparam logic [23:0] DIV100_RECIP = 24'd10737419;

endpackage

// ----- hw/rtl/kgoc_req_if.sv -----
interface kgoc_req_if;
   logic                    valid;
   logic                    ready;
   kgoc_pkg::key_level_type key_level;
   kgoc_pkg::sample_type    sample;
   logic                    enc_a;
   logic                    enc_b;
   logic                    enc_push;

   modport source (
      output valid, output key_level, output sample,
      output enc_a, output enc_b, output enc_push,
      input  ready
   );
   modport sink (
      input  valid, input key_level, input sample,
      input  enc_a, input enc_b, input enc_push,
      output ready
   );
endinterface

// ----- hw/rtl/kgoc_rsp_if.sv -----
interface kgoc_rsp_if;
   logic                 valid;
   logic                 ready;
   kgoc_pkg::mode_type   mode;
   kgoc_pkg::value_type  value;
   kgoc_pkg::value_type  lowest;
   kgoc_pkg::value_type  highest;
   kgoc_pkg::gain_type   gain_now;
   kgoc_pkg::offset_type offset_now;
   kgoc_pkg::step_type   step_now;
   logic                 fine_mode;

   modport source (
      output valid, output mode, output value, output lowest, output highest,
      output gain_now, output offset_now, output step_now, output fine_mode,
      input  ready
   );
   modport sink (
      input  valid, input mode, input value, input lowest, input highest,
      input  gain_now, input offset_now, input step_now, input fine_mode,
      output ready
   );
endinterface

// ----- hw/rtl/knob_tuned_gain_offset_conditioner.sv -----
// knob-tuned gain/offset conditioner
// req_bus carries one polling tick per word: keypad ladder level, 10-bit
// sample, encoder A/B levels and the encoder push level (0 = pressed).
// rsp_bus returns exactly one word per tick: mode, scaled value, tracked
// min/max, gain, offset, step and the fine flag, all in hundredths.
// csr_we/csr_index/csr_data write repeat_ticks (index 0) and
// clear_hold_ticks (index 1); write them only while no word is in flight.
// pipeline: three stages, the tick is registered in stage 1, then stage 2,
// then the output register (first stage: gain multiply, second: divide
// by 100 through a reciprocal multiply, third: state update into the
// output register); the two multipliers are each one stage
// throughput: one word per cycle while rsp_bus takes each word
// reset: synchronous, active high; the block comes up not started in mode 1
// with gain 1.00, offset 0, step 0.50, min/max zero and disarmed
// stall: when rsp_bus is not taken the words back up through the three
// registers and req_bus.ready drops once they are all full
module knob_tuned_gain_offset_conditioner (
   input  logic                   clock,
   input  logic                   reset,
   kgoc_req_if.sink               req_bus,
   kgoc_rsp_if.source             rsp_bus,
   input  logic                   csr_we,
   input  kgoc_pkg::csr_idx_type  csr_index,
   input  kgoc_pkg::csr_data_type csr_data
);

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free, adv2, s2_free, adv1, s1_free, accept;

   // stage 1 word
   kgoc_pkg::key_flags_type s1_keys_ff, s1_keys_in;
   logic [1:0]              s1_enc_ff;
   logic                    s1_push_ff;
   logic signed [31:0]      s1_prod_ff, s1_prod_in;

   // stage 2 word
   kgoc_pkg::key_flags_type s2_keys_ff;
   logic [1:0]              s2_enc_ff;
   logic                    s2_push_ff;
   logic                    s2_neg_ff, s2_neg_in;
   logic [46:0]             s2_scaled_ff, s2_scaled_in;

   // configuration
   kgoc_pkg::csr_data_type repeat_ticks_ff, clear_hold_ff;

   // block state
   logic                   started_ff, started_in;
   kgoc_pkg::mode_type     mode_ff, mode_in;
   logic                   sel_was_ff, sel_was_in;
   logic                   push_was_ff, push_was_in;
   logic                   fine_ff, fine_in;
   kgoc_pkg::quad_type     quad_ff, quad_in;
   kgoc_pkg::gain_type     gain_ff, gain_in;
   kgoc_pkg::offset_type   offset_ff, offset_in;
   kgoc_pkg::step_type     step_ff, step_in;
   kgoc_pkg::value_type    min_ff, min_in;
   kgoc_pkg::value_type    max_ff, max_in;
   logic                   armed_ff, armed_in;
   logic [15:0]            repeat_ff, repeat_in;
   logic [15:0]            hold_ff, hold_in;
   kgoc_pkg::value_type    value_in;

   // result register
   kgoc_pkg::mode_type   rsp_mode_ff;
   kgoc_pkg::value_type  rsp_value_ff, rsp_lowest_ff, rsp_highest_ff;
   kgoc_pkg::gain_type   rsp_gain_ff;
   kgoc_pkg::offset_type rsp_offset_ff;
   kgoc_pkg::step_type   rsp_step_ff;
   logic                 rsp_fine_ff;

   // stage 1 math
   logic [16:0]        samp_scaled;
   logic signed [18:0] level;
   logic signed [32:0] prod_wide;

   // stage 2 math
   logic [31:0] mag;
   logic [22:0] coarse;

   // stage 3 math
   logic [16:0]         quo;
   kgoc_pkg::value_type val;
   kgoc_pkg::value_type arm_min, arm_max;
   logic                keys_ok, push_release, fine_now, is_gain;
   logic [1:0]          quad_code;
   logic                quad_moved, enc_up, enc_dn;
   kgoc_pkg::quad_type  quad_shift;
   logic                mv_r, mv_l, mv_u, mv_d, key_used;
   logic signed [10:0]  inc, smax, st0, st1, st2;
   logic signed [15:0]  g0, g1, g2, gsum, gdif, st2_w;
   logic signed [10:0]  o0, o1, o2, osum, odif;
   logic [16:0]         hold_inc;
   logic                hold_hit;

   // handshake: a word moves on when the stage ahead is empty or moving
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign adv2     = s2_valid_ff && rsp_free;
   assign s2_free  = !s2_valid_ff || adv2;
   assign adv1     = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || adv1;
   assign accept   = req_bus.valid && s1_free;
   assign req_bus.ready = s1_free;

   assign s1_valid_in  = accept || (s1_valid_ff && !adv1);
   assign s2_valid_in  = adv1 || (s2_valid_ff && !adv2);
   assign rsp_valid_in = adv2 || (rsp_valid_ff && !rsp_bus.ready);

   // keypad ladder decode
   always_comb begin
      s1_keys_in.right = req_bus.key_level < kgoc_pkg::KEY_RIGHT_LT;
      s1_keys_in.up    = req_bus.key_level > kgoc_pkg::KEY_UP_GT &&
                         req_bus.key_level < kgoc_pkg::KEY_UP_LT;
      s1_keys_in.down  = req_bus.key_level > kgoc_pkg::KEY_DOWN_GT &&
                         req_bus.key_level < kgoc_pkg::KEY_DOWN_LT;
      s1_keys_in.left  = req_bus.key_level > kgoc_pkg::KEY_LEFT_GT &&
                         req_bus.key_level < kgoc_pkg::KEY_LEFT_LT;
      s1_keys_in.sel   = req_bus.key_level > kgoc_pkg::KEY_SEL_GT &&
                         req_bus.key_level < kgoc_pkg::KEY_SEL_LT;
   end

   // stage 1: gain * (125*sample + 256*offset)
   // gain and offset are read from committed state; a mode 1 tick always
   // trails the last gain or offset change by at least three ticks (select
   // edges and a release in between), so the words still in flight never
   // hold a change that this product should have seen
   assign samp_scaled = 17'(req_bus.sample) * 17'(kgoc_pkg::SAMPLE_MULT);
   assign level = $signed({2'b00, samp_scaled}) +
                  $signed({{2{offset_ff[8]}}, offset_ff, 8'h00});
   assign prod_wide  = $signed({1'b0, gain_ff}) * level;
   assign s1_prod_in = prod_wide[31:0];

   // stage 2: magnitude, drop the /256, then /100 by reciprocal multiply
   assign s2_neg_in    = s1_prod_ff[31];
   assign mag          = s2_neg_in ? 32'(-s1_prod_ff) : 32'(s1_prod_ff);
   assign coarse       = mag[30:8];
   assign s2_scaled_in = 47'(coarse) * 47'(kgoc_pkg::DIV100_RECIP);

   // stage 3: signed value, truncated toward zero
   assign quo = s2_scaled_ff[46:30];
   assign val = s2_neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

   // min/max arm on first mode 1 tick
   assign arm_min = armed_ff ? min_ff : 18'(kgoc_pkg::MINMAX_ARM);
   assign arm_max = armed_ff ? max_ff : 18'(-kgoc_pkg::MINMAX_ARM);

   assign keys_ok      = repeat_ff == '0;
   assign push_release = push_was_ff && !s2_push_ff;
   assign fine_now     = push_release ? !fine_ff : fine_ff;
   assign is_gain      = mode_ff == kgoc_pkg::MODE_GAIN;

   // quadrature decode on a change of the two-bit code
   assign quad_code  = s2_enc_ff;
   assign quad_moved = quad_ff[1:0] != quad_code;
   assign quad_shift = {quad_ff[3:0], quad_code};
   assign enc_up = quad_moved &&
                   (quad_shift == kgoc_pkg::QUAD_UP_A || quad_shift == kgoc_pkg::QUAD_UP_B);
   assign enc_dn = quad_moved &&
                   (quad_shift == kgoc_pkg::QUAD_DN_A || quad_shift == kgoc_pkg::QUAD_DN_B);

   assign mv_r = (keys_ok && s2_keys_ff.right) || (enc_up && fine_now);
   assign mv_l = (keys_ok && s2_keys_ff.left)  || (enc_dn && fine_now);
   assign mv_u = (keys_ok && s2_keys_ff.up)    || (enc_up && !fine_now);
   assign mv_d = (keys_ok && s2_keys_ff.down)  || (enc_dn && !fine_now);

   // step: right raises, then left lowers, each clamped
   assign inc  = is_gain ? 11'(kgoc_pkg::GAIN_STEP_INC) : 11'(kgoc_pkg::OFFSET_STEP_INC);
   assign smax = is_gain ? 11'(kgoc_pkg::GAIN_STEP_MAX) : 11'(kgoc_pkg::OFFSET_STEP_MAX);
   assign st0  = $signed({2'b00, step_ff});
   assign st1  = !mv_r ? st0 : ((st0 + inc > smax) ? smax : st0 + inc);
   assign st2  = !mv_l ? st1 : ((st1 - inc < inc) ? inc : st1 - inc);
   assign st2_w = 16'(st2);

   // gain: up then down, capped, never below one
   assign g0   = $signed({2'b00, gain_ff});
   assign gsum = g0 + st2_w;
   assign g1   = !mv_u ? g0 : ((gsum > kgoc_pkg::GAIN_MAX) ? 16'(kgoc_pkg::GAIN_MAX) : gsum);
   assign gdif = g1 - st2_w;
   assign g2   = !mv_d ? g1 : ((gdif < kgoc_pkg::GAIN_MIN) ? 16'(kgoc_pkg::GAIN_MIN) : gdif);

   // offset: up then down, kept within +/-2.50 V
   assign o0   = 11'(offset_ff);
   assign osum = o0 + st2;
   assign o1   = !mv_u ? o0 :
                 ((osum > kgoc_pkg::OFFSET_LIMIT) ? 11'(kgoc_pkg::OFFSET_LIMIT) : osum);
   assign odif = o1 - st2;
   assign o2   = !mv_d ? o1 :
                 ((odif < -kgoc_pkg::OFFSET_LIMIT) ? 11'(-kgoc_pkg::OFFSET_LIMIT) : odif);

   // clear hold; a limit of zero behaves as one
   assign hold_inc = {1'b0, hold_ff} + 17'd1;
   assign hold_hit = hold_inc >= {1'b0, clear_hold_ff};

   // next state for the word leaving stage 2
   always_comb begin
      started_in  = started_ff;
      mode_in     = mode_ff;
      fine_in     = fine_ff;
      quad_in     = quad_ff;
      gain_in     = gain_ff;
      offset_in   = offset_ff;
      step_in     = step_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      armed_in    = armed_ff;
      hold_in     = hold_ff;
      value_in    = '0;
      key_used    = 1'b0;
      repeat_in   = keys_ok ? repeat_ff : repeat_ff - 16'd1;
      push_was_in = s2_push_ff;
      sel_was_in  = s2_keys_ff.sel;

      if (s2_keys_ff.sel) begin
         // select edge starts the block or advances the mode
         if (!sel_was_ff) begin
            if (!started_ff) begin
               started_in = 1'b1;
            end else begin
               mode_in = (mode_ff >= kgoc_pkg::MODE_CLEAR) ? kgoc_pkg::MODE_RUN
                                                           : mode_ff + 3'd1;
               step_in = kgoc_pkg::STEP_RESET;
            end
         end
         hold_in = '0;
      end else if (started_ff) begin
         case (mode_ff)
            kgoc_pkg::MODE_RUN: begin
               value_in = val;
               min_in   = (val < arm_min) ? val : arm_min;
               max_in   = (val > arm_max) ? val : arm_max;
               armed_in = 1'b1;
               hold_in  = '0;
            end
            kgoc_pkg::MODE_GAIN, kgoc_pkg::MODE_OFFSET: begin
               quad_in  = quad_moved ? quad_shift : quad_ff;
               fine_in  = fine_now;
               key_used = keys_ok && (s2_keys_ff.right || s2_keys_ff.left ||
                                      s2_keys_ff.up || s2_keys_ff.down);
               step_in  = st2[8:0];
               if (is_gain) begin
                  gain_in = g2[13:0];
               end else begin
                  offset_in = o2[8:0];
               end
               hold_in  = '0;
            end
            kgoc_pkg::MODE_CLEAR: begin
               if (s2_keys_ff.right) begin
                  if (hold_hit) begin
                     min_in   = '0;
                     max_in   = '0;
                     armed_in = 1'b0;
                     hold_in  = '0;
                  end else begin
                     hold_in = hold_inc[15:0];
                  end
               end else begin
                  hold_in = '0;
               end
            end
            default: begin
               hold_in = hold_ff;
            end
         endcase
      end

      // any keypad adjustment restarts the repeat guard
      if (key_used) begin
         repeat_in = repeat_ticks_ff;
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_keys_ff <= s1_keys_in;
         s1_enc_ff  <= {req_bus.enc_a, req_bus.enc_b};
         s1_push_ff <= !req_bus.enc_push;
         s1_prod_ff <= s1_prod_in;
      end
      if (adv1) begin
         s2_keys_ff   <= s1_keys_ff;
         s2_enc_ff    <= s1_enc_ff;
         s2_push_ff   <= s1_push_ff;
         s2_neg_ff    <= s2_neg_in;
         s2_scaled_ff <= s2_scaled_in;
      end
      if (adv2) begin
         rsp_mode_ff    <= started_in ? mode_in : kgoc_pkg::MODE_OFF;
         rsp_value_ff   <= value_in;
         rsp_lowest_ff  <= min_in;
         rsp_highest_ff <= max_in;
         rsp_gain_ff    <= gain_in;
         rsp_offset_ff  <= offset_in;
         rsp_step_ff    <= step_in;
         rsp_fine_ff    <= fine_in;
      end
   end

   // block state, committed as each word enters the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff  <= 1'b0;
         mode_ff     <= kgoc_pkg::MODE_RUN;
         sel_was_ff  <= 1'b0;
         push_was_ff <= 1'b0;
         fine_ff     <= 1'b0;
         quad_ff     <= kgoc_pkg::QUAD_RESET;
         gain_ff     <= kgoc_pkg::GAIN_RESET;
         offset_ff   <= kgoc_pkg::OFFSET_RESET;
         step_ff     <= kgoc_pkg::STEP_RESET;
         min_ff      <= '0;
         max_ff      <= '0;
         armed_ff    <= 1'b0;
         repeat_ff   <= '0;
         hold_ff     <= '0;
      end else if (adv2) begin
         started_ff  <= started_in;
         mode_ff     <= mode_in;
         sel_was_ff  <= sel_was_in;
         push_was_ff <= push_was_in;
         fine_ff     <= fine_in;
         quad_ff     <= quad_in;
         gain_ff     <= gain_in;
         offset_ff   <= offset_in;
         step_ff     <= step_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         armed_ff    <= armed_in;
         repeat_ff   <= repeat_in;
         hold_ff     <= hold_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_ticks_ff <= kgoc_pkg::REPEAT_TICKS_RESET;
         clear_hold_ff   <= kgoc_pkg::CLEAR_HOLD_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            kgoc_pkg::CSR_REPEAT_TICKS:     repeat_ticks_ff <= csr_data;
            kgoc_pkg::CSR_CLEAR_HOLD_TICKS: clear_hold_ff   <= csr_data;
            default: begin
               repeat_ticks_ff <= repeat_ticks_ff;
            end
         endcase
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.mode       = rsp_mode_ff;
   assign rsp_bus.value      = rsp_value_ff;
   assign rsp_bus.lowest     = rsp_lowest_ff;
   assign rsp_bus.highest    = rsp_highest_ff;
   assign rsp_bus.gain_now   = rsp_gain_ff;
   assign rsp_bus.offset_now = rsp_offset_ff;
   assign rsp_bus.step_now   = rsp_step_ff;
   assign rsp_bus.fine_mode  = rsp_fine_ff;

endmodule

// ----- verif/tb_knob_tuned_gain_offset_conditioner.sv -----
module tb_knob_tuned_gain_offset_conditioner;

   // run limits
   localparam int CYCLE_LIMIT      = 400000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 6;

   // keypad classes used to build ladder levels
   typedef enum int {
      PAD_NONE, PAD_RIGHT, PAD_UP, PAD_DOWN, PAD_LEFT, PAD_SEL
   } pad_type;

   // one polling tick as it goes into the block
   typedef struct {
      kgoc_pkg::key_level_type key_level;
      kgoc_pkg::sample_type    sample;
      logic                    enc_a;
      logic                    enc_b;
      logic                    enc_push;
   } tick_type;

   // one result word as the block should return it
   typedef struct {
      kgoc_pkg::mode_type   mode;
      kgoc_pkg::value_type  value;
      kgoc_pkg::value_type  lowest;
      kgoc_pkg::value_type  highest;
      kgoc_pkg::gain_type   gain_now;
      kgoc_pkg::offset_type offset_now;
      kgoc_pkg::step_type   step_now;
      logic                 fine_mode;
   } reading_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   kgoc_pkg::csr_idx_type  csr_index;
   kgoc_pkg::csr_data_type csr_data;

   kgoc_req_if req_bus ();
   kgoc_rsp_if rsp_bus ();

   knob_tuned_gain_offset_conditioner DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // period 10, first rising edge at 5
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ticks waiting to be offered, readings waiting to come back
   tick_type    pending_ticks[$];
   reading_type expected_readings[$];

   // handshakes seen at the last rising edge
   bit req_took;
   bit rsp_took;

   // idling controls, set per phase
   int req_gap_max;
   int rsp_gap_max;
   int tick_gap;
   int word_wait;
   int hold_asked;
   int hold_done;

   int mismatch_count;
   int cycle_count;

   tick_type    nxt_tick;
   tick_type    seen_tick;
   reading_type want;

   // ------------------------------------------------------------------
   // conditioner state as predicted, reset values
   // ------------------------------------------------------------------
   int                 repeat_limit = kgoc_pkg::REPEAT_TICKS_RESET;
   int                 clear_limit  = kgoc_pkg::CLEAR_HOLD_TICKS_RESET;
   bit                 cnd_started  = 1'b0;
   int                 cnd_mode     = kgoc_pkg::MODE_RUN;
   bit                 cnd_sel_was  = 1'b0;
   bit                 cnd_push_was = 1'b0;
   bit                 cnd_fine     = 1'b0;
   kgoc_pkg::quad_type cnd_quad     = kgoc_pkg::QUAD_RESET;
   int                 cnd_gain     = kgoc_pkg::GAIN_RESET;
   int                 cnd_offset   = kgoc_pkg::OFFSET_RESET;
   int                 cnd_step     = kgoc_pkg::STEP_RESET;
   int                 cnd_low      = 0;
   int                 cnd_high     = 0;
   bit                 cnd_armed    = 1'b0;
   int                 cnd_repeat   = 0;
   int                 cnd_hold     = 0;

   // advance the conditioner by one tick and return the word it puts out
   function automatic reading_type condition_tick(tick_type t);
      kgoc_pkg::key_flags_type k;
      reading_type             r;
      bit                      keys_ok, key_used, push_down, push_release, gain_mode;
      bit                      go_r, go_l, go_u, go_d, enc_up, enc_dn;
      int                      value, inc, smax;
      longint                  num;
      logic [1:0]              code;
      k.right = t.key_level < kgoc_pkg::KEY_RIGHT_LT;
      k.up    = t.key_level > kgoc_pkg::KEY_UP_GT && t.key_level < kgoc_pkg::KEY_UP_LT;
      k.down  = t.key_level > kgoc_pkg::KEY_DOWN_GT && t.key_level < kgoc_pkg::KEY_DOWN_LT;
      k.left  = t.key_level > kgoc_pkg::KEY_LEFT_GT && t.key_level < kgoc_pkg::KEY_LEFT_LT;
      k.sel   = t.key_level > kgoc_pkg::KEY_SEL_GT && t.key_level < kgoc_pkg::KEY_SEL_LT;
      value = 0;
      keys_ok = (cnd_repeat == 0);
      key_used = 1'b0;
      push_down = !t.enc_push;
      push_release = cnd_push_was && !push_down;
      // repeat guard runs down on every tick
      if (cnd_repeat != 0) cnd_repeat--;
      cnd_push_was = push_down;

      if (k.sel) begin
         // only the press edge counts, no mode work while held
         if (!cnd_sel_was) begin
            if (!cnd_started) begin
               cnd_started = 1'b1;
            end else begin
               cnd_mode = (cnd_mode >= kgoc_pkg::MODE_CLEAR) ? kgoc_pkg::MODE_RUN
                                                             : cnd_mode + 1;
               cnd_step = kgoc_pkg::STEP_RESET;
            end
         end
         cnd_hold = 0;
      end else if (cnd_started) begin
         if (cnd_mode == kgoc_pkg::MODE_RUN) begin
            // hundredths, truncated toward zero
            num = longint'(cnd_gain) *
                  (longint'(t.sample) * 500 + longint'(cnd_offset) * 1024);
            value = int'(num / 102400);
            if (!cnd_armed) begin
               cnd_low = kgoc_pkg::MINMAX_ARM;
               cnd_high = -kgoc_pkg::MINMAX_ARM;
               cnd_armed = 1'b1;
            end
            if (value < cnd_low) cnd_low = value;
            if (value > cnd_high) cnd_high = value;
            cnd_hold = 0;
         end else if (cnd_mode == kgoc_pkg::MODE_GAIN || cnd_mode == kgoc_pkg::MODE_OFFSET) begin
            gain_mode = (cnd_mode == kgoc_pkg::MODE_GAIN);
            inc = gain_mode ? kgoc_pkg::GAIN_STEP_INC : kgoc_pkg::OFFSET_STEP_INC;
            smax = gain_mode ? kgoc_pkg::GAIN_STEP_MAX : kgoc_pkg::OFFSET_STEP_MAX;
            // encoder history shifts only on a change of the a/b code
            enc_up = 1'b0;
            enc_dn = 1'b0;
            code = {t.enc_a, t.enc_b};
            if (cnd_quad[1:0] != code) begin
               cnd_quad = {cnd_quad[3:0], code};
               enc_up = (cnd_quad == kgoc_pkg::QUAD_UP_A) || (cnd_quad == kgoc_pkg::QUAD_UP_B);
               enc_dn = (cnd_quad == kgoc_pkg::QUAD_DN_A) || (cnd_quad == kgoc_pkg::QUAD_DN_B);
            end
            if (push_release) cnd_fine = !cnd_fine;
            go_r = (keys_ok && k.right) || (enc_up && cnd_fine);
            go_l = (keys_ok && k.left) || (enc_dn && cnd_fine);
            go_u = (keys_ok && k.up) || (enc_up && !cnd_fine);
            go_d = (keys_ok && k.down) || (enc_dn && !cnd_fine);
            key_used = keys_ok && (k.right || k.left || k.up || k.down);
            if (go_r) begin
               cnd_step += inc;
               if (cnd_step > smax) cnd_step = smax;
            end
            if (go_l) begin
               cnd_step -= inc;
               if (cnd_step < inc) cnd_step = inc;
            end
            if (gain_mode) begin
               if (go_u) begin
                  cnd_gain += cnd_step;
                  if (cnd_gain > kgoc_pkg::GAIN_MAX) cnd_gain = kgoc_pkg::GAIN_MAX;
               end
               if (go_d) begin
                  cnd_gain -= cnd_step;
                  if (cnd_gain <= 0) cnd_gain = kgoc_pkg::GAIN_MIN;
               end
            end else begin
               if (go_u) begin
                  cnd_offset += cnd_step;
                  if (cnd_offset > kgoc_pkg::OFFSET_LIMIT) cnd_offset = kgoc_pkg::OFFSET_LIMIT;
               end
               if (go_d) begin
                  cnd_offset -= cnd_step;
                  if (cnd_offset < -kgoc_pkg::OFFSET_LIMIT)
                     cnd_offset = -kgoc_pkg::OFFSET_LIMIT;
               end
            end
            cnd_hold = 0;
         end else begin
            // clear mode: right must stay held, a limit of 0 clears at once
            if (k.right) begin
               cnd_hold++;
               if (cnd_hold >= clear_limit) begin
                  cnd_low = 0;
                  cnd_high = 0;
                  cnd_armed = 1'b0;
                  cnd_hold = 0;
               end
            end else begin
               cnd_hold = 0;
            end
         end
      end
      cnd_sel_was = k.sel;
      if (key_used) cnd_repeat = repeat_limit;

      r.mode       = cnd_started ? kgoc_pkg::mode_type'(cnd_mode) : kgoc_pkg::MODE_OFF;
      r.value      = kgoc_pkg::value_type'(value);
      r.lowest     = kgoc_pkg::value_type'(cnd_low);
      r.highest    = kgoc_pkg::value_type'(cnd_high);
      r.gain_now   = kgoc_pkg::gain_type'(cnd_gain);
      r.offset_now = kgoc_pkg::offset_type'(cnd_offset);
      r.step_now   = kgoc_pkg::step_type'(cnd_step);
      r.fine_mode  = cnd_fine;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // stimulus building: tracks select edges so sequences know the mode
   // ------------------------------------------------------------------
   int         gen_mode     = 0;
   bit         gen_sel_down = 1'b0;
   logic [1:0] gen_quad     = 2'b11;
   logic       gen_push     = 1'b1;
   int         gen_count    = 0;

   task automatic queue_tick(int key, int smp, logic [1:0] q, logic push);
      tick_type t;
      bit       is_sel;
      t.key_level = kgoc_pkg::key_level_type'(key);
      t.sample    = kgoc_pkg::sample_type'(smp);
      t.enc_a     = q[1];
      t.enc_b     = q[0];
      t.enc_push  = push;
      pending_ticks.push_back(t);
      gen_count++;
      is_sel = t.key_level > kgoc_pkg::KEY_SEL_GT && t.key_level < kgoc_pkg::KEY_SEL_LT;
      if (is_sel && !gen_sel_down) begin
         if (gen_mode == 0) gen_mode = kgoc_pkg::MODE_RUN;
         else gen_mode = (gen_mode >= kgoc_pkg::MODE_CLEAR) ? kgoc_pkg::MODE_RUN
                                                           : gen_mode + 1;
      end
      gen_sel_down = is_sel;
      gen_quad = q;
      gen_push = push;
   endtask

   // random ladder level inside a key's band
   function automatic int level_of(pad_type kind);
      case (kind)
         PAD_RIGHT: return $urandom_range(0, kgoc_pkg::KEY_RIGHT_LT - 1);
         PAD_UP:    return $urandom_range(kgoc_pkg::KEY_UP_GT + 1, kgoc_pkg::KEY_UP_LT - 1);
         PAD_DOWN:  return $urandom_range(kgoc_pkg::KEY_DOWN_GT + 1, kgoc_pkg::KEY_DOWN_LT - 1);
         PAD_LEFT:  return $urandom_range(kgoc_pkg::KEY_LEFT_GT + 1, kgoc_pkg::KEY_LEFT_LT - 1);
         PAD_SEL:   return $urandom_range(kgoc_pkg::KEY_SEL_GT + 1, kgoc_pkg::KEY_SEL_LT - 1);
         default: begin
            // gaps between the bands
            case ($urandom_range(0, 4))
               0: return $urandom_range(kgoc_pkg::KEY_RIGHT_LT, kgoc_pkg::KEY_UP_GT);
               1: return $urandom_range(kgoc_pkg::KEY_UP_LT, kgoc_pkg::KEY_DOWN_GT);
               2: return $urandom_range(kgoc_pkg::KEY_DOWN_LT, kgoc_pkg::KEY_LEFT_GT);
               3: return $urandom_range(kgoc_pkg::KEY_LEFT_LT, kgoc_pkg::KEY_SEL_GT);
               default: return $urandom_range(kgoc_pkg::KEY_SEL_LT, 1023);
            endcase
         end
      endcase
   endfunction

   function automatic int rand_sample();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1023;
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   // quadrature gray sequence, cw 00-10-11-01, ccw 00-01-11-10
   function automatic logic [1:0] next_code(logic [1:0] q, bit cw);
      if (cw) begin
         case (q)
            2'b00: return 2'b10;
            2'b10: return 2'b11;
            2'b11: return 2'b01;
            default: return 2'b00;
         endcase
      end else begin
         case (q)
            2'b00: return 2'b01;
            2'b01: return 2'b11;
            2'b11: return 2'b10;
            default: return 2'b00;
         endcase
      end
   endfunction

   // wait until nothing is offered or outstanding, then let the pipe settle
   task automatic drain();
      while (pending_ticks.size() != 0 || expected_readings.size() != 0 || req_bus.valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(kgoc_pkg::csr_idx_type idx, kgoc_pkg::csr_data_type d);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == kgoc_pkg::CSR_REPEAT_TICKS) repeat_limit = d;
      else clear_limit = d;
   endtask

   // one phase: settings written while idle, then random episodes, then drain
   task automatic run_phase(int rep, int clr, int sgap, int rgap, bit long_hold, int items);
      int      target, len, actions, pick, m;
      pad_type kind;
      bit      cw;
      write_reg(kgoc_pkg::CSR_REPEAT_TICKS, kgoc_pkg::csr_data_type'(rep));
      write_reg(kgoc_pkg::CSR_CLEAR_HOLD_TICKS, kgoc_pkg::csr_data_type'(clr));
      req_gap_max = sgap;
      rsp_gap_max = rgap;
      // receiver stalls long while the sender keeps offering
      if (long_hold) hold_asked++;
      target = gen_count + items;
      while (gen_count < target) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: any field value, broken encoder codes, stray selects
            len = $urandom_range(1, 8);
            repeat (len)
               queue_tick($urandom_range(0, 1023), rand_sample(),
                          2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         end else begin
            pick = $urandom_range(0, 9);
            m = (pick < 3) ? kgoc_pkg::MODE_RUN : (pick < 6) ? kgoc_pkg::MODE_GAIN :
                (pick < 9) ? kgoc_pkg::MODE_OFFSET : kgoc_pkg::MODE_CLEAR;
            // step through select presses up to the wanted mode
            while (gen_mode != m || gen_sel_down) begin
               if (gen_sel_down)
                  queue_tick(level_of(PAD_NONE), rand_sample(), gen_quad, gen_push);
               else
                  queue_tick(level_of(PAD_SEL), rand_sample(), gen_quad, gen_push);
            end
            if (m == kgoc_pkg::MODE_RUN) begin
               len = $urandom_range(3, 30);
               repeat (len)
                  queue_tick(level_of(pad_type'($urandom_range(PAD_NONE, PAD_LEFT))),
                             rand_sample(), 2'($urandom_range(0, 3)),
                             1'($urandom_range(0, 1)));
            end else if (m == kgoc_pkg::MODE_CLEAR) begin
               len = $urandom_range(1, (clear_limit < 20) ? clear_limit + 2 : 20);
               repeat (len) queue_tick(level_of(PAD_RIGHT), rand_sample(), gen_quad, gen_push);
               queue_tick(level_of(pad_type'($urandom_range(PAD_NONE, PAD_LEFT))),
                          rand_sample(), gen_quad, gen_push);
            end else begin
               actions = $urandom_range(1, 10);
               repeat (actions) begin
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3: begin
                        // keypad key held for a while
                        kind = pad_type'($urandom_range(PAD_RIGHT, PAD_LEFT));
                        len = $urandom_range(1, 40);
                        repeat (len) queue_tick(level_of(kind), rand_sample(), gen_quad, gen_push);
                     end
                     4, 5, 6: begin
                        // clean rotation one way
                        cw = $urandom_range(0, 1);
                        len = $urandom_range(1, 16);
                        repeat (len)
                           queue_tick(level_of(PAD_NONE), rand_sample(),
                                      next_code(gen_quad, cw), gen_push);
                     end
                     7, 8: begin
                        // push and release, turning now and then while held
                        len = $urandom_range(1, 4);
                        repeat (len)
                           queue_tick(level_of(PAD_NONE), rand_sample(),
                                      $urandom_range(0, 1) ? next_code(gen_quad, 1'b1) : gen_quad,
                                      1'b0);
                        queue_tick(level_of(PAD_NONE), rand_sample(), gen_quad, 1'b1);
                     end
                     default:
                        queue_tick(level_of(pad_type'($urandom_range(PAD_NONE, PAD_LEFT))),
                                   rand_sample(), gen_quad, gen_push);
                  endcase
               end
            end
         end
      end
      // sender pauses here until every word is back
      drain();
   endtask

   // ------------------------------------------------------------------
   // request driver: changes on the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         tick_gap = 0;
      end else begin
         if (req_bus.valid && req_took) tick_gap = $urandom_range(0, req_gap_max);
         if (!req_bus.valid || req_took) begin
            if (tick_gap == 0 && pending_ticks.size() != 0) begin
               nxt_tick = pending_ticks.pop_front();
               req_bus.key_level <= nxt_tick.key_level;
               req_bus.sample    <= nxt_tick.sample;
               req_bus.enc_a     <= nxt_tick.enc_a;
               req_bus.enc_b     <= nxt_tick.enc_b;
               req_bus.enc_push  <= nxt_tick.enc_push;
               req_bus.valid     <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
               if (tick_gap != 0) tick_gap--;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // response side ready: random wait per word, long hold on request
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         word_wait = 0;
      end else begin
         if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            word_wait = LONG_HOLD_CYCLES;
         end else if (rsp_took) begin
            word_wait = $urandom_range(0, rsp_gap_max);
         end
         if (word_wait != 0) begin
            rsp_bus.ready <= 1'b0;
            word_wait--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic check_field(string name, logic signed [31:0] want_v,
                              logic signed [31:0] got_v);
      if (got_v !== want_v) begin
         // report and count every mismatch
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // monitor: sample on the rising edge, predict accepted ticks, check words
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_took = 1'b0;
         rsp_took = 1'b0;
      end else begin
         req_took = req_bus.valid && req_bus.ready;
         rsp_took = rsp_bus.valid && rsp_bus.ready;
         if (req_took) begin
            seen_tick.key_level = req_bus.key_level;
            seen_tick.sample    = req_bus.sample;
            seen_tick.enc_a     = req_bus.enc_a;
            seen_tick.enc_b     = req_bus.enc_b;
            seen_tick.enc_push  = req_bus.enc_push;
            expected_readings.push_back(condition_tick(seen_tick));
         end
         if (rsp_took) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: word with nothing expected, expected none, got mode %0d value %0d",
                        $time, rsp_bus.mode, rsp_bus.value);
               mismatch_count++;
            end else begin
               want = expected_readings.pop_front();
               check_field("mode", want.mode, rsp_bus.mode);
               check_field("value", want.value, rsp_bus.value);
               check_field("lowest", want.lowest, rsp_bus.lowest);
               check_field("highest", want.highest, rsp_bus.highest);
               check_field("gain_now", want.gain_now, rsp_bus.gain_now);
               check_field("offset_now", want.offset_now, rsp_bus.offset_now);
               check_field("step_now", want.step_now, rsp_bus.step_now);
               check_field("fine_mode", want.fine_mode, rsp_bus.fine_mode);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[knob_tuned_gain_offset_conditioner] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // sequence of the run
   // ------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = kgoc_pkg::CSR_REPEAT_TICKS;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.key_level = '0;
      req_bus.sample = '0;
      req_bus.enc_a = 1'b1;
      req_bus.enc_b = 1'b1;
      req_bus.enc_push = 1'b1;
      rsp_bus.ready = 1'b0;
      req_gap_max = 2;
      rsp_gap_max = 2;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, registers at reset values
      queue_tick(1023, 1023, 2'b11, 1'b1);   // idle before start, no key at top level
      queue_tick(0, 0, 2'b11, 1'b1);         // right before start is ignored
      queue_tick(150, 512, 2'b11, 1'b1);     // up before start is ignored
      queue_tick(701, 1023, 2'b11, 1'b1);    // select edge starts the block
      queue_tick(989, 1023, 2'b11, 1'b1);    // select held, no edge, no work
      queue_tick(990, 1023, 2'b11, 1'b1);    // first run tick arms min/max
      queue_tick(49, 0, 2'b11, 1'b1);        // right in run mode does nothing
      queue_tick(50, 700, 2'b11, 1'b1);
      queue_tick(100, 1, 2'b11, 1'b1);
      queue_tick(700, 300, 2'b11, 1'b1);     // just below the select band
      queue_tick(988, 512, 2'b11, 1'b1);     // to gain mode, step back to 0.50
      queue_tick(200, 512, 2'b11, 1'b1);
      queue_tick(101, 512, 2'b11, 1'b1);     // keypad up arms the repeat guard
      queue_tick(349, 512, 2'b11, 1'b1);     // down swallowed by the guard
      queue_tick(650, 512, 2'b01, 1'b1);     // encoder turns cw while guarded
      queue_tick(260, 512, 2'b00, 1'b1);     // completes an up step
      queue_tick(1023, 512, 2'b00, 1'b0);    // push held
      queue_tick(1023, 512, 2'b00, 1'b1);    // release toggles fine mode
      queue_tick(351, 512, 2'b10, 1'b1);
      queue_tick(400, 512, 2'b11, 1'b1);     // fine step up on rotation
      queue_tick(800, 512, 2'b11, 1'b1);     // to offset mode
      queue_tick(401, 512, 2'b10, 1'b1);
      queue_tick(900, 512, 2'b00, 1'b1);     // to clear mode
      queue_tick(0, 512, 2'b00, 1'b1);       // right held one tick, short of the limit
      queue_tick(701, 1023, 2'b00, 1'b1);    // back to run mode
      queue_tick(1000, 1023, 2'b00, 1'b1);
      drain();

      // random phases, hardest register values last so the guard stays quiet before
      run_phase(0, 0, 5, 5, 1'b0, 345);
      run_phase(3, 5, 0, 0, 1'b1, 345);
      run_phase($urandom_range(1, 12), $urandom_range(2, 16), 5, 5, 1'b0, 345);
      run_phase(1, 1, 3, 0, 1'b0, 345);
      run_phase(16'hFFFF, 16'hFFFF, 5, 5, 1'b0, 345);

      if (mismatch_count == 0) begin
         $display("[knob_tuned_gain_offset_conditioner] OK");
      end else begin
         $display("[knob_tuned_gain_offset_conditioner] ERROR");
      end
      $finish;
   end

endmodule
